[rtl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, codes, types and the sequencer state type of the DDA line
// rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  // Coordinate and fixed-point formats.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Size registers are 13 bits wide.
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;

  // Position carries two guard bits over the coordinate range.
  localparam int POS_W  = COORD_BITS + FRAC_BITS + 2;
  // An increment lies in [-1.0, +1.0].
  localparam int STEP_W = FRAC_BITS + 2;
  // Dividend of the increment division: |delta| << FRAC_BITS plus half the span.
  localparam int DVD_W  = COORD_BITS + FRAC_BITS;
  localparam int CNT_W  = $clog2(DVD_W);
  // Integer part of a rounded magnitude.
  localparam int RND_W  = POS_W + 1 - FRAC_BITS;
  // Width used for the window compare.
  localparam int CMP_W  = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(800);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(600);

  // Operation codes of an input transaction.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // One rounded pixel with its window flag.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         inw;
  } pix_t;

  // Control and status between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_X,
    S_WAIT_X,
    S_LOAD_Y,
    S_WAIT_Y,
    S_ADV
  } state_t;

endpackage

`default_nettype wire

[rtl/dda_ifs.sv]
// ----------------------------------------------------------------------------
// dda_ifs
// Valid/ready channel interfaces of the DDA line rasterizer: line input,
// pixel output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dda_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic signed [dda_pkg::COORD_BITS-1:0]   start_x;
  logic signed [dda_pkg::COORD_BITS-1:0]   start_y;
  logic signed [dda_pkg::COORD_BITS-1:0]   end_x;
  logic signed [dda_pkg::COORD_BITS-1:0]   end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dda_pkg::COORD_BITS-1:0]   pixel_x;
  logic signed [dda_pkg::COORD_BITS-1:0]   pixel_y;
  logic                                    pixel_valid;
  logic                                    in_window;
  logic                                    last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, in_window, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, in_window, last_pixel,
                  output ready);
endinterface

interface dda_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dda_pkg::CFG_IDX_W-1:0]       index;
  logic [dda_pkg::CFG_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/dda_div.sv]
// ----------------------------------------------------------------------------
// dda_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by both
// increment divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dda_pkg::div_ctl_t                  ctl,
  input  wire logic [dda_pkg::DVD_W-1:0]          dividend,
  input  wire logic [dda_pkg::COORD_BITS-1:0]     divisor,
  output dda_pkg::div_sts_t                       sts,
  output logic [dda_pkg::DVD_W-1:0]               quotient
);

  logic [dda_pkg::COORD_BITS-1:0] rem_r;
  logic [dda_pkg::DVD_W-1:0]      quo_r;
  logic [dda_pkg::CNT_W-1:0]      cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [dda_pkg::COORD_BITS:0]   trial;
  logic                           fits;
  logic [dda_pkg::COORD_BITS:0]   diff;
  logic                           cnt_last;

  // The partial remainder always stays below the divisor, so the difference
  // fits back into the remainder register.
  assign trial    = {rem_r, quo_r[dda_pkg::DVD_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign cnt_last = cnt_r == dda_pkg::CNT_W'(dda_pkg::DVD_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !ctl.start && busy_r && cnt_last;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[dda_pkg::COORD_BITS-1:0] : trial[dda_pkg::COORD_BITS-1:0];
      quo_r <= {quo_r[dda_pkg::DVD_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[rtl/dda_pix.sv]
// ----------------------------------------------------------------------------
// dda_pix
// Rounds a fixed-point position to integer pixel coordinates, half away from
// zero with saturation, and flags whether the pixel lies in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_pix (
  input  wire logic signed [dda_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [dda_pkg::POS_W-1:0]  pos_y,
  input  wire logic [dda_pkg::CFG_W-1:0]         width,
  input  wire logic [dda_pkg::CFG_W-1:0]         height,
  output dda_pkg::pix_t                          pix
);

  localparam int HALF    = 1 << (dda_pkg::FRAC_BITS - 1);
  localparam int MAG_POS = (1 << (dda_pkg::COORD_BITS - 1)) - 1;
  localparam int MAG_NEG = 1 << (dda_pkg::COORD_BITS - 1);

  function automatic logic [dda_pkg::COORD_BITS-1:0] round_coord(
    input logic [dda_pkg::POS_W-1:0] v
  );
    logic                            neg;
    logic [dda_pkg::POS_W-1:0]       m;
    logic [dda_pkg::POS_W:0]         s;
    logic [dda_pkg::RND_W-1:0]       r;
    logic [dda_pkg::COORD_BITS-1:0]  rl;
    neg = v[dda_pkg::POS_W-1];
    m   = neg ? (~v + 1'b1) : v;
    s   = {1'b0, m} + (dda_pkg::POS_W + 1)'(HALF);
    r   = s[dda_pkg::POS_W:dda_pkg::FRAC_BITS];
    if (neg) begin
      if (r > dda_pkg::RND_W'(MAG_NEG)) r = dda_pkg::RND_W'(MAG_NEG);
      rl = r[dda_pkg::COORD_BITS-1:0];
      return ~rl + 1'b1;
    end else begin
      if (r > dda_pkg::RND_W'(MAG_POS)) r = dda_pkg::RND_W'(MAG_POS);
      return r[dda_pkg::COORD_BITS-1:0];
    end
  endfunction

  logic [dda_pkg::COORD_BITS-1:0] x;
  logic [dda_pkg::COORD_BITS-1:0] y;
  logic [dda_pkg::CMP_W-1:0]      xz;
  logic [dda_pkg::CMP_W-1:0]      yz;

  assign x  = round_coord(pos_x);
  assign y  = round_coord(pos_y);
  assign xz = dda_pkg::CMP_W'(x);
  assign yz = dda_pkg::CMP_W'(y);

  assign pix.x   = x;
  assign pix.y   = y;
  assign pix.inw = !x[dda_pkg::COORD_BITS-1] && !y[dda_pkg::COORD_BITS-1] &&
                   (xz < dda_pkg::CMP_W'(width)) && (yz < dda_pkg::CMP_W'(height));

endmodule

`default_nettype wire

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: a start transaction loads two endpoints, each step
// transaction returns the next pixel of the line, endpoint included.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Carries
//   in_if    sink       valid/ready    op, start_x, start_y, end_x, end_y
//   out_if   source     valid/ready    pixel_x, pixel_y, pixel_valid,
//                                      in_window, last_pixel
//   cfg_if   sink       valid/ready    index, data (always ready)
//
// Steps can be accepted back to back while the output register drains. A start
// transaction places its first pixel in the output register at once, then the
// block is not ready while the single radix-2 divider produces the x and then
// the y increment, one quotient bit per cycle. A zero-length line needs no
// division and the block stays ready. Reset is synchronous and active low; it
// clears the sequencer, the line-active flag, the pixel count, the output valid
// flag and the size registers (800 by 600). A stalled output holds its
// transaction and blocks new input until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dda_in_if.sink     in_if,
  dda_out_if.source  out_if,
  dda_cfg_if.sink    cfg_if
);

  localparam int CB = dda_pkg::COORD_BITS;
  localparam int FB = dda_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // Size registers. User writes only while the block is idle; not enforced.
  // --------------------------------------------------------------------------
  logic [dda_pkg::CFG_W-1:0] width_r;
  logic [dda_pkg::CFG_W-1:0] height_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dda_pkg::WIDTH_RST;
      height_r <= dda_pkg::HEIGHT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        dda_pkg::REG_WIDTH:  width_r  <= cfg_if.data;
        dda_pkg::REG_HEIGHT: height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Line state and sequencer.
  // --------------------------------------------------------------------------
  dda_pkg::state_t state_r;
  dda_pkg::state_t state_nxt;

  logic signed [dda_pkg::POS_W-1:0]  pos_x_r;
  logic signed [dda_pkg::POS_W-1:0]  pos_y_r;
  logic signed [dda_pkg::STEP_W-1:0] step_x_r;
  logic signed [dda_pkg::STEP_W-1:0] step_y_r;
  logic [CB-1:0]                     pixels_left_r;
  logic                              line_active_r;

  // Span of the line being divided, with the delta magnitudes and signs.
  logic [CB-1:0] side_r;
  logic [CB-1:0] mag_x_r;
  logic [CB-1:0] mag_y_r;
  logic          neg_x_r;
  logic          neg_y_r;

  // Output register.
  logic                  out_valid_r;
  logic signed [CB-1:0]  out_x_r;
  logic signed [CB-1:0]  out_y_r;
  logic                  out_inw_r;
  logic                  out_last_r;

  // Sequencer outputs.
  logic in_ready;
  logic div_sel_y;
  dda_pkg::div_ctl_t div_ctl;
  dda_pkg::div_sts_t div_sts;

  logic out_free;
  assign out_free = !out_valid_r || out_if.ready;

  logic in_acc;
  logic is_start;
  assign in_acc   = in_if.valid && in_ready;
  assign is_start = in_if.op == dda_pkg::OP_START;

  // Deltas and the step count of a new line.
  logic signed [CB:0] dx;
  logic signed [CB:0] dy;
  logic [CB:0]        adx;
  logic [CB:0]        ady;
  logic [CB-1:0]      mdx;
  logic [CB-1:0]      mdy;
  logic [CB-1:0]      side;

  assign dx   = {in_if.end_x[CB-1], in_if.end_x} - {in_if.start_x[CB-1], in_if.start_x};
  assign dy   = {in_if.end_y[CB-1], in_if.end_y} - {in_if.start_y[CB-1], in_if.start_y};
  assign adx  = dx[CB] ? (~dx + 1'b1) : dx;
  assign ady  = dy[CB] ? (~dy + 1'b1) : dy;
  assign mdx  = adx[CB-1:0];
  assign mdy  = ady[CB-1:0];
  assign side = (mdx >= mdy) ? mdx : mdy;

  logic side_zero;
  assign side_zero = side == '0;

  // Start position in fixed point.
  logic signed [dda_pkg::POS_W-1:0] start_pos_x;
  logic signed [dda_pkg::POS_W-1:0] start_pos_y;
  assign start_pos_x = {{(dda_pkg::POS_W-CB-FB){in_if.start_x[CB-1]}},
                        in_if.start_x, {FB{1'b0}}};
  assign start_pos_y = {{(dda_pkg::POS_W-CB-FB){in_if.start_y[CB-1]}},
                        in_if.start_y, {FB{1'b0}}};

  // The pixel of a start transaction is its start point; a step returns the
  // current accumulated position.
  dda_pkg::pix_t pix;

  dda_pix u_pix (
    .pos_x  (is_start ? start_pos_x : pos_x_r),
    .pos_y  (is_start ? start_pos_y : pos_y_r),
    .width  (width_r),
    .height (height_r),
    .pix    (pix)
  );

  // Divider operands: |delta| << FRAC_BITS plus half the span, so the
  // quotient comes out rounded half away from zero.
  logic [dda_pkg::DVD_W-1:0] dividend;
  logic [dda_pkg::DVD_W-1:0] quotient;
  logic [FB:0]               q;
  logic                      q_neg;
  logic signed [dda_pkg::STEP_W-1:0] step_new;

  assign dividend = {(div_sel_y ? mag_y_r : mag_x_r), {FB{1'b0}}} +
                    dda_pkg::DVD_W'(side_r >> 1);
  assign q        = quotient[FB:0];
  assign q_neg    = div_sel_y ? neg_y_r : neg_x_r;
  assign step_new = q_neg ? -dda_pkg::STEP_W'(q) : dda_pkg::STEP_W'(q);

  dda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (dividend),
    .divisor  (side_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dda_pkg::S_IDLE: begin
        if (in_acc && is_start && !side_zero) state_nxt = dda_pkg::S_LOAD_X;
      end
      dda_pkg::S_LOAD_X: state_nxt = dda_pkg::S_WAIT_X;
      dda_pkg::S_WAIT_X: begin
        if (div_sts.done) state_nxt = dda_pkg::S_LOAD_Y;
      end
      dda_pkg::S_LOAD_Y: state_nxt = dda_pkg::S_WAIT_Y;
      dda_pkg::S_WAIT_Y: begin
        if (div_sts.done) state_nxt = dda_pkg::S_ADV;
      end
      dda_pkg::S_ADV:    state_nxt = dda_pkg::S_IDLE;
      default:           state_nxt = dda_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    div_ctl.start = 1'b0;
    div_sel_y     = 1'b0;
    case (state_r)
      dda_pkg::S_IDLE:   in_ready = out_free;
      dda_pkg::S_LOAD_X: div_ctl.start = 1'b1;
      dda_pkg::S_WAIT_X: div_sel_y = 1'b0;
      dda_pkg::S_LOAD_Y: begin
        div_ctl.start = 1'b1;
        div_sel_y     = 1'b1;
      end
      dda_pkg::S_WAIT_Y: div_sel_y = 1'b1;
      dda_pkg::S_ADV:    div_sel_y = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  assign in_if.ready = in_ready;

  // A transaction produces a pixel for every start and for a step while a
  // line is still running; a step with no line is taken and dropped.
  logic out_load;
  logic step_last;
  assign out_load  = in_acc && (is_start || line_active_r);
  assign step_last = pixels_left_r == CB'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dda_pkg::S_IDLE;
      line_active_r <= 1'b0;
      pixels_left_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;

      if (in_acc && is_start) begin
        line_active_r <= 1'b0;
        pixels_left_r <= side;
      end else if (in_acc && line_active_r) begin
        pixels_left_r <= pixels_left_r - 1'b1;
        if (step_last) line_active_r <= 1'b0;
      end else if (state_r == dda_pkg::S_ADV) begin
        line_active_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= pix.x;
      out_y_r    <= pix.y;
      out_inw_r  <= pix.inw;
      out_last_r <= is_start ? side_zero : step_last;
    end

    if (in_acc && is_start) begin
      pos_x_r  <= start_pos_x;
      pos_y_r  <= start_pos_y;
      side_r   <= side;
      mag_x_r  <= mdx;
      mag_y_r  <= mdy;
      neg_x_r  <= dx[CB];
      neg_y_r  <= dy[CB];
      step_x_r <= '0;
      step_y_r <= '0;
    end else if (in_acc && line_active_r) begin
      pos_x_r <= pos_x_r + dda_pkg::POS_W'(step_x_r);
      pos_y_r <= pos_y_r + dda_pkg::POS_W'(step_y_r);
    end else if (state_r == dda_pkg::S_ADV) begin
      // The first pixel went to the output register at the start; move on to the second.
      pos_x_r <= pos_x_r + dda_pkg::POS_W'(step_x_r);
      pos_y_r <= pos_y_r + dda_pkg::POS_W'(step_y_r);
    end

    if (state_r == dda_pkg::S_WAIT_X && div_sts.done) step_x_r <= step_new;
    if (state_r == dda_pkg::S_WAIT_Y && div_sts.done) step_y_r <= step_new;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pixel_x     = out_x_r;
  assign out_if.pixel_y     = out_y_r;
  assign out_if.pixel_valid = 1'b1;
  assign out_if.in_window   = out_inw_r;
  assign out_if.last_pixel  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A running line always has pixels left to return.
  a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    line_active_r |-> pixels_left_r != '0)
    else $error("line active with no pixels left");

  // The divider finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == dda_pkg::S_WAIT_X || state_r == dda_pkg::S_WAIT_Y))
    else $error("divider result outside a wait state");

  // A start transaction with a nonzero span blocks the input while dividing.
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_start && !side_zero) |=> !in_if.ready)
    else $error("input ready right after a dividing start");

  // The step that returns the final pixel ends the line.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_start && line_active_r && step_last) |=> !line_active_r)
    else $error("line still active after its last pixel");

endmodule

`default_nettype wire
